@@ rtl/mwsm_pkg.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mwsm_pkg
// Shared constants and tables for the mecanum wheel speed mixer.
// -----------------------------------------------------------------------------
package mwsm_pkg;

   localparam int CordicSteps     = 16;
   localparam int AngleBitsDefault = 16;
   localparam int GainQ16         = 39797;
   localparam int XyWidth         = 34;    // Q.16 command after CORDIC growth
   localparam int ZWidth          = 33;    // 2^32 units per turn, signed
   localparam int WheelWidth      = 33;    // wheel term at Q.16
   localparam int SumWidth        = 35;
   localparam int NumWidth        = 50;    // 4*base_speed times wheel term
   localparam int QuotWidth       = 16;
   localparam logic [34:0] OneQ28 = 35'd268435456;
   localparam logic [12:0] BaseSpeedReset = 13'd4000;
   localparam logic [0:0]  RegBaseSpeed = 1'b0;

   function automatic logic [ZWidth-1:0] atan_lookup(input int idx);
      logic [ZWidth-1:0] val;
      case (idx)
         0:  val = 33'd536870912;
         1:  val = 33'd316933406;
         2:  val = 33'd167458907;
         3:  val = 33'd85004756;
         4:  val = 33'd42667331;
         5:  val = 33'd21354465;
         6:  val = 33'd10679838;
         7:  val = 33'd5340245;
         8:  val = 33'd2670163;
         9:  val = 33'd1335087;
         10: val = 33'd667544;
         11: val = 33'd333772;
         12: val = 33'd166886;
         13: val = 33'd83443;
         14: val = 33'd41722;
         15: val = 33'd20861;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

@@ rtl/mwsm_divider.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mwsm_divider
// Pipelined restoring divider: one quotient bit per stage, one item per cycle.
// Signed dividend, positive divisor, quotient truncated toward zero.
// -----------------------------------------------------------------------------
module mwsm_divider
   import mwsm_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic signed [NumWidth-1:0] in_num,
   input  logic [SumWidth-1:0]        in_den,
   input  logic                       in_zero,
   output logic                       out_valid,
   output logic signed [QuotWidth-1:0] out_quot
);
   // |quotient| <= 4*8191 < 2^15, so 15 bits of magnitude are produced.
   localparam int QBits = QuotWidth - 1;
   localparam int RemWidth = SumWidth + 1;

   logic                 vld_ff   [QBits+1];
   logic [RemWidth-1:0]  rem_ff   [QBits+1];
   logic [NumWidth-1:0]  mag_ff   [QBits+1];
   logic [SumWidth-1:0]  den_ff   [QBits+1];
   logic [QBits-1:0]     quo_ff   [QBits+1];
   logic                 neg_ff   [QBits+1];
   logic                 zero_ff  [QBits+1];

   logic [NumWidth-1:0] mag_in;
   assign mag_in = in_num[NumWidth-1] ? NumWidth'(-in_num) : in_num;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
      // Quotient fits QBits, so |num| >> QBits is already below the divisor.
      rem_ff[0]  <= RemWidth'(mag_in >> QBits);
      mag_ff[0]  <= mag_in;
      den_ff[0]  <= in_den;
      quo_ff[0]  <= '0;
      neg_ff[0]  <= in_num[NumWidth-1];
      zero_ff[0] <= in_zero;
   end

   for (genvar s = 0; s < QBits; s++) begin : g_stage
      logic [RemWidth-1:0] trial_in;
      logic [RemWidth-1:0] diff_in;
      logic                take_in;
      logic [QBits-1:0]    quo_in;
      always_comb begin
         // Bring down the remaining low bits, starting at bit QBits-1.
         trial_in = (rem_ff[s] << 1) | RemWidth'(mag_ff[s][QBits-1-s]);
         diff_in  = trial_in - RemWidth'(den_ff[s]);
         take_in  = trial_in >= RemWidth'(den_ff[s]);
         quo_in   = {quo_ff[s][QBits-2:0], take_in};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else begin
            vld_ff[s+1] <= vld_ff[s];
         end
         rem_ff[s+1]  <= take_in ? diff_in : trial_in;
         mag_ff[s+1]  <= mag_ff[s];
         den_ff[s+1]  <= den_ff[s];
         quo_ff[s+1]  <= quo_in;
         neg_ff[s+1]  <= neg_ff[s];
         zero_ff[s+1] <= zero_ff[s];
      end
   end

   logic [QuotWidth-1:0] q_ext;
   assign q_ext = {1'b0, quo_ff[QBits]};
   assign out_valid = vld_ff[QBits];
   assign out_quot  = zero_ff[QBits] ? '0
                    : (neg_ff[QBits] ? QuotWidth'(-q_ext) : q_ext);

endmodule

@@ rtl/mecanum_wheel_speed_mixer.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mecanum_wheel_speed_mixer
// Rotates the translation command by the heading, mixes in yaw and
// normalises four wheel setpoints against base_speed.
// -----------------------------------------------------------------------------
// Usage:
//   Raise req_start with a command item while req_busy is low; busy never
//   rises, so one item is taken every cycle. The item walks a pre-rotation
//   stage, a pipeline of CORDIC stages (one micro-rotation each), a gain
//   multiply, a mixing stage, a sum stage, a scale multiply, a bit-per-stage
//   divider and an output register. Throughput is one item per cycle, set
//   by the divider and CORDIC pipelines.
//   rsp_valid is high for one cycle with the four wheel speeds; the
//   receiver cannot stall, so nothing is held back.
//   base_speed is read and written over the csr_ APB port at address 0;
//   write it only while no items are in flight.
//   Reset clears all valid bits and sets base_speed to 4000.
// -----------------------------------------------------------------------------
module mecanum_wheel_speed_mixer
   import mwsm_pkg::*;
#(
   parameter int ANGLE_BITS = AngleBitsDefault
)(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_start,
   output logic               req_busy,
   input  logic signed [15:0] req_forward_cmd,
   input  logic signed [15:0] req_right_cmd,
   input  logic signed [15:0] req_yaw_cmd,
   input  logic signed [15:0] req_heading_angle,
   input  logic               req_link_ok,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_wheel0_speed,
   output logic signed [15:0] rsp_wheel1_speed,
   output logic signed [15:0] rsp_wheel2_speed,
   output logic signed [15:0] rsp_wheel3_speed,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [1:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   typedef logic signed [XyWidth-1:0] xy_type;
   typedef logic signed [ZWidth-1:0]  z_type;

   localparam logic [15:0] AngleMask = 16'(16'hFFFF << (16 - ANGLE_BITS));

   // ---------------- configuration ----------------
   logic [12:0] base_speed_ff;
   assign csr_pready = 1'b1;
   assign req_busy   = 1'b0;
   always_ff @(posedge clock) begin
      if (reset) begin
         base_speed_ff <= BaseSpeedReset;
      end else if (csr_psel && csr_penable && csr_pwrite
                   && csr_paddr[1:0] == {RegBaseSpeed, 1'b0}) begin
         base_speed_ff <= csr_pwdata[12:0];
      end
   end
   assign csr_prdata = (csr_paddr == {RegBaseSpeed, 1'b0}) ? {19'd0, base_speed_ff} : '0;

   // ---------------- stage 0: pre-rotation ----------------
   logic   v0_ff, link0_ff;
   xy_type x0_ff, y0_ff, yaw0_ff;
   z_type  z0_ff;
   xy_type x_in, y_in;
   z_type  z_in;
   always_comb begin
      z_in = z_type'(signed'(req_heading_angle & AngleMask)) <<< 16;
      x_in = xy_type'(req_forward_cmd) <<< 16;
      y_in = xy_type'(req_right_cmd) <<< 16;
      if (z_in > z_type'(33'sd1073741824)) begin
         x_in = -x_in; y_in = -y_in; z_in = z_in - z_type'(34'sd2147483648);
      end else if (z_in < -z_type'(33'sd1073741824)) begin
         x_in = -x_in; y_in = -y_in; z_in = z_in + z_type'(34'sd2147483648);
      end
   end
   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else       v0_ff <= req_start;
      x0_ff <= x_in; y0_ff <= y_in; z0_ff <= z_in;
      yaw0_ff  <= xy_type'(req_yaw_cmd) <<< 16;
      link0_ff <= req_link_ok;
   end

   // ---------------- CORDIC stages ----------------
   logic   cv_ff   [CordicSteps+1];
   logic   clink_ff[CordicSteps+1];
   xy_type cx_ff   [CordicSteps+1];
   xy_type cy_ff   [CordicSteps+1];
   xy_type cyaw_ff [CordicSteps+1];
   z_type  cz_ff   [CordicSteps+1];
   always_comb begin
      cv_ff[0] = v0_ff; clink_ff[0] = link0_ff;
      cx_ff[0] = x0_ff; cy_ff[0] = y0_ff; cz_ff[0] = z0_ff; cyaw_ff[0] = yaw0_ff;
   end
   for (genvar k = 0; k < CordicSteps; k++) begin : g_cordic
      xy_type dx_in, dy_in;
      assign dx_in = cy_ff[k] >>> k;
      assign dy_in = cx_ff[k] >>> k;
      always_ff @(posedge clock) begin
         if (reset) cv_ff[k+1] <= 1'b0;
         else       cv_ff[k+1] <= cv_ff[k];
         if (!cz_ff[k][ZWidth-1]) begin
            cx_ff[k+1] <= cx_ff[k] - dx_in;
            cy_ff[k+1] <= cy_ff[k] + dy_in;
            cz_ff[k+1] <= cz_ff[k] - z_type'(atan_lookup(k));
         end else begin
            cx_ff[k+1] <= cx_ff[k] + dx_in;
            cy_ff[k+1] <= cy_ff[k] - dy_in;
            cz_ff[k+1] <= cz_ff[k] + z_type'(atan_lookup(k));
         end
         cyaw_ff[k+1]  <= cyaw_ff[k];
         clink_ff[k+1] <= clink_ff[k];
      end
   end

   // ---------------- gain removal ----------------
   logic        g_v_ff, g_link_ff;
   logic signed [XyWidth+17-1:0] ga_ff, gb_ff;
   xy_type g_yaw_ff;
   always_ff @(posedge clock) begin
      if (reset) g_v_ff <= 1'b0;
      else       g_v_ff <= cv_ff[CordicSteps];
      ga_ff <= cx_ff[CordicSteps] * $signed({1'b0, 16'(GainQ16)});
      gb_ff <= cy_ff[CordicSteps] * $signed({1'b0, 16'(GainQ16)});
      g_yaw_ff  <= cyaw_ff[CordicSteps];
      g_link_ff <= clink_ff[CordicSteps];
   end

   // ---------------- mixing ----------------
   typedef logic signed [WheelWidth+1:0] wheel_type;
   logic m_v_ff, m_link_ff;
   wheel_type w_ff [4];
   wheel_type a_in, b_in, yaw_in;
   assign a_in   = wheel_type'(ga_ff >>> 16);
   assign b_in   = wheel_type'(gb_ff >>> 16);
   assign yaw_in = wheel_type'(g_yaw_ff);
   always_ff @(posedge clock) begin
      if (reset) m_v_ff <= 1'b0;
      else       m_v_ff <= g_v_ff;
      m_link_ff <= g_link_ff;
      w_ff[0] <= a_in + b_in + yaw_in;
      w_ff[1] <= -a_in + b_in + yaw_in;
      w_ff[2] <= a_in - b_in + yaw_in;
      w_ff[3] <= -a_in - b_in + yaw_in;
   end

   // ---------------- sum of magnitudes ----------------
   logic s_v_ff, s_link_ff;
   logic [SumWidth-1:0] sum_ff;
   wheel_type sw_ff [4];
   logic [SumWidth-1:0] sum_in;
   always_comb begin
      sum_in = '0;
      for (int i = 0; i < 4; i++)
         sum_in = sum_in + SumWidth'(w_ff[i][WheelWidth+1] ? -w_ff[i] : w_ff[i]);
      if (sum_in < OneQ28) sum_in = OneQ28;
   end
   always_ff @(posedge clock) begin
      if (reset) s_v_ff <= 1'b0;
      else       s_v_ff <= m_v_ff;
      s_link_ff <= m_link_ff;
      sum_ff    <= sum_in;
      for (int i = 0; i < 4; i++) sw_ff[i] <= w_ff[i];
   end

   // ---------------- scale ----------------
   logic p_v_ff, p_link_ff;
   logic [SumWidth-1:0] p_sum_ff;
   logic signed [NumWidth-1:0] num_ff [4];
   always_ff @(posedge clock) begin
      if (reset) p_v_ff <= 1'b0;
      else       p_v_ff <= s_v_ff;
      p_link_ff <= s_link_ff;
      p_sum_ff  <= sum_ff;
      for (int i = 0; i < 4; i++)
         num_ff[i] <= NumWidth'(sw_ff[i])
                      * NumWidth'($signed({1'b0, base_speed_ff, 2'b00}));
   end

   // ---------------- dividers ----------------
   logic               dv [4];
   logic signed [15:0] dq [4];
   for (genvar i = 0; i < 4; i++) begin : g_div
      mwsm_divider u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (p_v_ff),
         .in_num    (num_ff[i]),
         .in_den    (p_sum_ff),
         .in_zero   (!p_link_ff),
         .out_valid (dv[i]),
         .out_quot  (dq[i])
      );
   end

   logic rsp_valid_ff;
   logic signed [15:0] wo_ff [4];
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= dv[0] & dv[1] & dv[2] & dv[3];
      for (int i = 0; i < 4; i++) wo_ff[i] <= dq[i];
   end
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_wheel0_speed = wo_ff[0];
   assign rsp_wheel1_speed = wo_ff[1];
   assign rsp_wheel2_speed = wo_ff[2];
   assign rsp_wheel3_speed = wo_ff[3];

endmodule

@@ rtl/mwsm_checker.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mwsm_checker
// Port-level checks for the mecanum wheel speed mixer.
// -----------------------------------------------------------------------------
module mwsm_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_start,
   input logic               req_busy,
   input logic               rsp_valid,
   input logic signed [15:0] rsp_wheel0_speed,
   input logic signed [15:0] rsp_wheel1_speed,
   input logic               csr_pready
);
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !req_busy)
      else $error("busy raised");
   a_ready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("pready low");
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_start, 38))
      else $error("result without item");
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_wheel0_speed <= 16'sd32764 && rsp_wheel0_speed >= -16'sd32764
                     && rsp_wheel1_speed <= 16'sd32764 && rsp_wheel1_speed >= -16'sd32764))
      else $error("wheel setpoint out of range");
   a_after_reset: assert property (@(posedge clock) $fell(reset) |-> !rsp_valid)
      else $error("result right after reset");
endmodule

bind mecanum_wheel_speed_mixer mwsm_checker u_mwsm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_start        (req_start),
   .req_busy         (req_busy),
   .rsp_valid        (rsp_valid),
   .rsp_wheel0_speed (rsp_wheel0_speed),
   .rsp_wheel1_speed (rsp_wheel1_speed),
   .csr_pready       (csr_pready)
);

@@ sim/tb_mecanum_wheel_speed_mixer.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_mecanum_wheel_speed_mixer
// Drives directed and randomly bursted command items into the wheel speed mixer and
// checks every set of wheel setpoints against a CORDIC-based predictor.
// Steps base_speed through its extremes over the csr_ port between phases.
// -----------------------------------------------------------------------------
module tb_mecanum_wheel_speed_mixer;
   import mwsm_pkg::*;

   localparam int  DrainCycles = 50;
   localparam int  WatchLimit  = 5000;
   localparam longint QuarterTurn = 64'sd1073741824;
   localparam longint HalfTurn    = 64'sd2147483648;
   localparam longint OneTurnQ28  = 64'sd268435456;

   typedef struct packed {
      logic signed [15:0] fwd;
      logic signed [15:0] right;
      logic signed [15:0] yaw;
      logic signed [15:0] heading;
      logic               link_ok;
   } command_type;

   typedef struct packed {
      logic signed [15:0] w0;
      logic signed [15:0] w1;
      logic signed [15:0] w2;
      logic signed [15:0] w3;
   } wheel_set_type;

   logic               clock;
   logic               reset;
   logic               req_start;
   logic               req_busy;
   logic signed [15:0] req_forward_cmd;
   logic signed [15:0] req_right_cmd;
   logic signed [15:0] req_yaw_cmd;
   logic signed [15:0] req_heading_angle;
   logic               req_link_ok;
   logic               rsp_valid;
   logic signed [15:0] rsp_wheel0_speed;
   logic signed [15:0] rsp_wheel1_speed;
   logic signed [15:0] rsp_wheel2_speed;
   logic signed [15:0] rsp_wheel3_speed;
   logic               csr_psel;
   logic               csr_penable;
   logic               csr_pwrite;
   logic [1:0]         csr_paddr;
   logic [31:0]        csr_pwdata;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   wheel_set_type pending_wheels[$];
   logic [12:0]   base_speed_mirror;
   int            error_count;
   int            idle_cycles;
   longint        arctan_steps[16] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861};

   mecanum_wheel_speed_mixer u_dut (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic wheel_set_type mix_wheels(command_type c, logic [12:0] base);
      longint        x, y, z, dx, dy, a, b, yaw, total, scale;
      longint        w[4];
      wheel_set_type r;
      r = '0;
      if (!c.link_ok) return r;
      x   = longint'(c.fwd) * 65536;
      y   = longint'(c.right) * 65536;
      yaw = longint'(c.yaw) * 65536;
      z   = longint'(c.heading) * 65536;
      // fold the angle into +-90 degrees by turning the vector half a turn
      if (z > QuarterTurn) begin
         x = -x; y = -y; z -= HalfTurn;
      end else if (z < -QuarterTurn) begin
         x = -x; y = -y; z += HalfTurn;
      end
      for (int k = 0; k < 16; k++) begin
         dx = y >>> k;
         dy = x >>> k;
         if (z >= 0) begin
            x -= dx; y += dy; z -= arctan_steps[k];
         end else begin
            x += dx; y -= dy; z += arctan_steps[k];
         end
      end
      a = (x * 39797) >>> 16;
      b = (y * 39797) >>> 16;
      w[0] = a + b + yaw;
      w[1] = -a + b + yaw;
      w[2] = a - b + yaw;
      w[3] = -a - b + yaw;
      total = 0;
      for (int k = 0; k < 4; k++) total += (w[k] < 0) ? -w[k] : w[k];
      if (total < OneTurnQ28) total = OneTurnQ28;
      scale = longint'(base) * 4;
      r.w0 = 16'((scale * w[0]) / total);
      r.w1 = 16'((scale * w[1]) / total);
      r.w2 = 16'((scale * w[2]) / total);
      r.w3 = 16'((scale * w[3]) / total);
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
      error_count++;
   endtask

   // check each setpoint set against the oldest prediction
   always @(posedge clock) begin
      wheel_set_type e;
      if (!reset && rsp_valid) begin
         if (pending_wheels.size() == 0) begin
            report_mismatch("unexpected result", 1, 0);
         end else begin
            e = pending_wheels.pop_front();
            if (rsp_wheel0_speed !== e.w0) report_mismatch("wheel0", rsp_wheel0_speed, e.w0);
            if (rsp_wheel1_speed !== e.w1) report_mismatch("wheel1", rsp_wheel1_speed, e.w1);
            if (rsp_wheel2_speed !== e.w2) report_mismatch("wheel2", rsp_wheel2_speed, e.w2);
            if (rsp_wheel3_speed !== e.w3) report_mismatch("wheel3", rsp_wheel3_speed, e.w3);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_start && !req_busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchLimit) begin
         $display("tb_mecanum_wheel_speed_mixer: done, errors");
         $finish;
      end
   end

   // hold start high into the next item; the caller lowers it for gaps
   task automatic send_command(command_type c);
      logic free;
      req_start         <= 1'b1;
      req_forward_cmd   <= c.fwd;
      req_right_cmd     <= c.right;
      req_yaw_cmd       <= c.yaw;
      req_heading_angle <= c.heading;
      req_link_ok       <= c.link_ok;
      do begin
         @(negedge clock);
         free = !req_busy;
         @(posedge clock);
      end while (!free);
      pending_wheels.push_back(mix_wheels(c, base_speed_mirror));
   endtask

   task automatic pause_sender(int n);
      req_start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain_results();
      req_start <= 1'b0;
      while (pending_wheels.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_base_speed(logic [12:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= 2'(RegBaseSpeed * 4);
      csr_pwdata  <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      base_speed_mirror = value;
      @(posedge clock);
   endtask

   task automatic check_base_speed_readback();
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= 2'(RegBaseSpeed * 4);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      @(negedge clock);
      if (csr_prdata[12:0] !== base_speed_mirror)
         report_mismatch("base_speed readback", csr_prdata[12:0], base_speed_mirror);
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic logic signed [15:0] pick_value();
      case ($urandom_range(0, 5))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'($urandom_range(0, 8192)) - 16'sd4096;
         3:       return 16'sd0;
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic command_type random_command();
      command_type c;
      c.fwd     = pick_value();
      c.right   = pick_value();
      c.yaw     = pick_value();
      c.heading = ($urandom_range(0, 7) == 0) ? pick_value() : 16'($urandom());
      c.link_ok = ($urandom_range(0, 9) != 0);
      return c;
   endfunction

   task automatic test_directed();
      command_type c[$];
      c.push_back('{16'sd4096, 16'sd0, 16'sd0, 16'sd0, 1'b1});
      c.push_back('{16'sd0, 16'sd4096, 16'sd0, 16'sd0, 1'b1});
      c.push_back('{16'sd0, 16'sd0, 16'sd4096, 16'sd0, 1'b1});
      c.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1});         // all zero
      c.push_back('{16'sd4096, 16'sd4096, 16'sd4096, 16'sd0, 1'b0}); // link down
      c.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1});
      c.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1}); // 180 deg
      c.push_back('{16'sd4096, 16'sd0, 16'sd0, 16'sh8000, 1'b1});
      c.push_back('{16'sd4096, 16'sd0, 16'sd0, 16'sd16384, 1'b1});
      c.push_back('{16'sd4096, 16'sd0, 16'sd0, -16'sd16384, 1'b1});
      c.push_back('{16'sd4096, 16'sd0, 16'sd0, 16'sd16385, 1'b1});
      c.push_back('{16'sd4096, 16'sd0, 16'sd0, -16'sd16385, 1'b1});
      c.push_back('{16'sh8000, 16'sh7FFF, 16'sd0, 16'sd8192, 1'b1});
      c.push_back('{16'sd1, -16'sd1, 16'sd1, 16'sd1, 1'b1});
      c.push_back('{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 1'b0});
      c.push_back('{16'sd100, 16'sd200, -16'sd300, 16'sd12345, 1'b1});
      foreach (c[i]) send_command(c[i]);
      drain_results();
   endtask

   task automatic test_random_bursts(int n);
      int sent;
      sent = 0;
      while (sent < n) begin
         repeat ($urandom_range(1, 40)) begin
            if (sent < n) begin
               send_command(random_command());
               sent++;
            end
         end
         if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 6));
      end
      drain_results();
   endtask

   task automatic test_base_speed_settings();
      logic [12:0] settings[6] = '{13'd0, 13'd8000, 13'd1, 13'd8191, 13'd4000, 13'd2500};
      foreach (settings[i]) begin
         write_base_speed(settings[i]);
         check_base_speed_readback();
         test_random_bursts(150);
      end
      write_base_speed(13'($urandom_range(0, 8191)));
      test_random_bursts(150);
   endtask

   initial begin
      error_count       = 0;
      base_speed_mirror = BaseSpeedReset;
      reset             = 1'b1;
      req_start         = 1'b0;
      req_forward_cmd   = '0;
      req_right_cmd     = '0;
      req_yaw_cmd       = '0;
      req_heading_angle = '0;
      req_link_ok       = 1'b0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_base_speed_readback();
      test_directed();
      test_random_bursts(600);
      test_base_speed_settings();
      if (error_count == 0) begin
         $display("tb_mecanum_wheel_speed_mixer: done, clean");
      end else begin
         $display("tb_mecanum_wheel_speed_mixer: done, errors");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/mwsm_pkg.sv
rtl/mwsm_divider.sv
rtl/mecanum_wheel_speed_mixer.sv
rtl/mwsm_checker.sv
sim/tb_mecanum_wheel_speed_mixer.sv
